FILE: sv/skp_pkg.sv
package skp_pkg;

	localparam int KEY_W = 31;
	localparam int PIX_W = 8;
	localparam int IDX_W = 6;
	localparam int SIZE_W = 7;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PIX_W-1:0] pix;
		logic [IDX_W-1:0] idx;
	} cell_data_t;

	// One command per cycle, broadcast to every cell of the chain.
	typedef struct packed {
		logic load;
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

FILE: sv/skp_cell.sv
module skp_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  skp_pkg::cell_ctrl_t ctrl,
	input  skp_pkg::cell_data_t new_data,
	input  logic                left_ins,
	input  logic                left_valid,
	input  skp_pkg::cell_data_t left_data,
	input  logic                right_valid,
	input  skp_pkg::cell_data_t right_data,
	output logic                valid,
	output skp_pkg::cell_data_t data,
	output logic                ins
);

	logic                valid_q;
	skp_pkg::cell_data_t data_q;

	// Empty cell or smaller key: the new pair lands here or further up.
	assign ins   = !valid_q || (data_q.key < new_data.key);
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end else if (ctrl.load && ins) begin
			valid_q <= left_ins ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= right_data;
		end else if (ctrl.load && ins) begin
			data_q <= left_ins ? left_data : new_data;
		end
	end

endmodule

FILE: sv/sort_key_pixel_permutation.sv
// Chan  Handshake             Payload                        Dir  Accepted when
// in    in_valid, in_stall    req_type, sort_key, pixel      in   in_valid & !in_stall
// out   out_valid, out_stall  out_pixel, source_index, last  out  out_valid & !out_stall
// cfg   cfg_valid, cfg_ready  used_size                      in   cfg_valid & cfg_ready
//
// Requests act as they are accepted: a load is placed into the insertion chain of
// BLOCK_SIZE cells in the cycle it is accepted, a fetch shifts the chain one
// cell toward its head in the cycle it is accepted, or clears it on the last fetch.
// arst_n clears all cell valid bits and counters at once, no clearing pass.
// in_stall is high only while a result waits in the output register and
// out_stall holds it there. A write to used_size empties the block.
module sort_key_pixel_permutation #(
	parameter int BLOCK_SIZE = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic [skp_pkg::KEY_W-1:0]    sort_key,
	input  logic [skp_pkg::PIX_W-1:0]    pixel,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [skp_pkg::PIX_W-1:0]    out_pixel,
	output logic [skp_pkg::IDX_W-1:0]    source_index,
	output logic                         last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [skp_pkg::SIZE_W-1:0]   used_size
);

	localparam int CW = $clog2(BLOCK_SIZE + 1);
	localparam int WW = (CW > skp_pkg::SIZE_W) ? CW : skp_pkg::SIZE_W;

	logic [skp_pkg::SIZE_W-1:0] used_size_q;
	logic [CW-1:0]              load_count_q;
	logic [CW-1:0]              fetch_count_q;

	logic                         out_valid_q;
	logic [skp_pkg::PIX_W-1:0]    out_pixel_q;
	logic [skp_pkg::IDX_W-1:0]    out_index_q;
	logic                         out_last_q;

	logic [WW-1:0] used_w;
	logic [WW-1:0] blk_w;
	logic [CW-1:0] blk_n;
	logic          accept;
	logic          cfg_wr;
	logic          do_load;
	logic          do_fetch;
	logic          fin;

	skp_pkg::cell_ctrl_t ctrl;
	skp_pkg::cell_data_t new_data;
	skp_pkg::cell_data_t cell_data  [BLOCK_SIZE];
	logic                cell_valid [BLOCK_SIZE];
	logic                cell_ins   [BLOCK_SIZE];

	// Clamp the block length to 1..BLOCK_SIZE.
	assign used_w = WW'(used_size_q);
	always_comb begin
		if (used_w == '0) begin
			blk_w = WW'(1);
		end else if (used_w > WW'(BLOCK_SIZE)) begin
			blk_w = WW'(BLOCK_SIZE);
		end else begin
			blk_w = used_w;
		end
	end
	assign blk_n = CW'(blk_w);

	// Hold requests only while a finished result is parked.
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Drop loads into a full block; drop fetches before it fills.
	assign do_load  = accept && !req_type && (load_count_q < blk_n);
	assign do_fetch = accept && req_type && (load_count_q >= blk_n)
	                  && (fetch_count_q < load_count_q);
	assign fin      = ({1'b0, fetch_count_q} + (CW+1)'(1)) >= {1'b0, blk_n};

	assign new_data.key = sort_key;
	assign new_data.pix = pixel;
	assign new_data.idx = skp_pkg::IDX_W'(load_count_q);

	assign ctrl.load  = do_load && !cfg_wr;
	assign ctrl.shift = do_fetch && !cfg_wr && !fin;
	assign ctrl.clear = cfg_wr || (do_fetch && fin);

	for (genvar i = 0; i < BLOCK_SIZE; i++) begin : g_cell
		logic                left_ins;
		logic                left_valid;
		skp_pkg::cell_data_t left_data;
		logic                right_valid;
		skp_pkg::cell_data_t right_data;

		if (i == 0) begin : g_head
			assign left_ins   = 1'b0;
			assign left_valid = 1'b0;
			assign left_data  = '0;
		end else begin : g_body
			assign left_ins   = cell_ins[i-1];
			assign left_valid = cell_valid[i-1];
			assign left_data  = cell_data[i-1];
		end

		if (i == BLOCK_SIZE - 1) begin : g_tail
			assign right_valid = 1'b0;
			assign right_data  = '0;
		end else begin : g_mid
			assign right_valid = cell_valid[i+1];
			assign right_data  = cell_data[i+1];
		end

		skp_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_data    (new_data),
			.left_ins    (left_ins),
			.left_valid  (left_valid),
			.left_data   (left_data),
			.right_valid (right_valid),
			.right_data  (right_data),
			.valid       (cell_valid[i]),
			.data        (cell_data[i]),
			.ins         (cell_ins[i])
		);
	end

	// Counters and the block length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_size_q   <= skp_pkg::SIZE_RESET;
			load_count_q  <= '0;
			fetch_count_q <= '0;
		end else if (cfg_wr) begin
			used_size_q   <= used_size;
			load_count_q  <= '0;
			fetch_count_q <= '0;
		end else if (do_load) begin
			load_count_q  <= load_count_q + CW'(1);
		end else if (do_fetch) begin
			if (fin) begin
				load_count_q  <= '0;
				fetch_count_q <= '0;
			end else begin
				fetch_count_q <= fetch_count_q + CW'(1);
			end
		end
	end

	// Output register: the head cell is always the current rank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_fetch) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_fetch) begin
			out_pixel_q <= cell_data[0].pix;
			out_index_q <= cell_data[0].idx;
			out_last_q  <= fin;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_pixel    = out_pixel_q;
	assign source_index = out_index_q;
	assign last         = out_last_q;

endmodule

FILE: dv/skp_tb_pkg.sv
package skp_tb_pkg;

	// Request kinds carried on req_type
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	// Block depth the bench builds the block with
	localparam int BLOCK_DEPTH = 64;

endpackage

FILE: dv/sort_perm_monitor.sv
module sort_perm_monitor
	import skp_pkg::*;
	import skp_tb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              req_type,
	input  logic [KEY_W-1:0]  sort_key,
	input  logic [PIX_W-1:0]  pixel,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [PIX_W-1:0]  out_pixel,
	input  logic [IDX_W-1:0]  source_index,
	input  logic              last,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [SIZE_W-1:0] used_size,
	output int                pending,
	output int                fail_count,
	output int                result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 50;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [IDX_W-1:0] src;
		logic             fin;
	} ranked_pixel_t;

	// Loaded pairs, kept in descending key order
	logic [KEY_W-1:0] rank_key [BLOCK_DEPTH];
	logic [PIX_W-1:0] rank_pix [BLOCK_DEPTH];
	logic [IDX_W-1:0] rank_src [BLOCK_DEPTH];
	int loaded;
	int fetched;
	int span;
	ranked_pixel_t due_q [$];
	int errors = 0;
	int results = 0;

	// Out-of-range sizes fold to 1 or to the full depth
	function automatic int clamp_span(input logic [SIZE_W-1:0] size);
		if (size == 0)
			return 1;
		if (size > BLOCK_DEPTH)
			return BLOCK_DEPTH;
		return int'(size);
	endfunction

	// Insert after every stored key that is greater or equal, so ties keep load order
	task automatic place_pair(input logic [KEY_W-1:0] key, input logic [PIX_W-1:0] pix);
		int pos;
		pos = 0;
		while (pos < loaded && rank_key[pos] >= key)
			pos++;
		for (int j = loaded; j > pos; j--) begin
			rank_key[j] = rank_key[j-1];
			rank_pix[j] = rank_pix[j-1];
			rank_src[j] = rank_src[j-1];
		end
		rank_key[pos] = key;
		rank_pix[pos] = pix;
		rank_src[pos] = IDX_W'(loaded);
		loaded++;
	endtask

	task automatic rank_request(input logic kind, input logic [KEY_W-1:0] key,
			input logic [PIX_W-1:0] pix);
		ranked_pixel_t r;
		if (kind == REQ_LOAD) begin
			if (loaded < span)
				place_pair(key, pix);
		end else if (loaded >= span && fetched < loaded) begin
			r.pix = rank_pix[fetched];
			r.src = rank_src[fetched];
			r.fin = (fetched + 1 >= span);
			due_q.push_back(r);
			if (r.fin) begin
				loaded = 0;
				fetched = 0;
			end else begin
				fetched++;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < PRINT_CAP)
			$display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	// Check results first: a result accepted now never stems from a request accepted now
	always @(posedge clk or negedge arst_n) begin
		ranked_pixel_t want;
		if (!arst_n) begin
			loaded = 0;
			fetched = 0;
			span = clamp_span(SIZE_RESET);
			due_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results++;
				if (due_q.size() == 0) begin
					report_mismatch("result with nothing expected, out_pixel", out_pixel, 0);
				end else begin
					want = due_q.pop_front();
					if (out_pixel !== want.pix)
						report_mismatch("out_pixel", out_pixel, want.pix);
					if (source_index !== want.src)
						report_mismatch("source_index", source_index, want.src);
					if (last !== want.fin)
						report_mismatch("last", last, want.fin);
				end
			end
			if (cfg_valid && cfg_ready) begin
				span = clamp_span(used_size);
				loaded = 0;
				fetched = 0;
			end
			if (in_valid && !in_stall)
				rank_request(req_type, sort_key, pixel);
			pending <= due_q.size();
		end
		fail_count <= errors;
		result_count <= results;
	end

endmodule

FILE: dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import skp_pkg::*;
	import skp_tb_pkg::*;

	localparam int ITEM_GOAL      = 1650;
	localparam int IDLE_PCT       = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 8;
	localparam int QUIET_FROM     = 700;
	localparam int QUIET_TO       = 1000;
	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

	// How keys are drawn for one block
	typedef enum int {
		KEYS_RANDOM,
		KEYS_TIED,
		KEYS_EDGES
	} key_mix_e;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              req_type;
	logic [KEY_W-1:0]  sort_key;
	logic [PIX_W-1:0]  pixel;
	logic              out_valid;
	logic              out_stall;
	logic [PIX_W-1:0]  out_pixel;
	logic [IDX_W-1:0]  source_index;
	logic              last;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [SIZE_W-1:0] used_size;

	int  pending;
	int  fail_count;
	int  result_count;
	int  requests_sent = 0;
	int  size_writes = 0;
	bit  no_gaps;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	sort_key_pixel_permutation #(
		.BLOCK_SIZE(BLOCK_DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.sort_key     (sort_key),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_pixel    (out_pixel),
		.source_index (source_index),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.used_size    (used_size)
	);

	// Monitor sits beside the block: it predicts every result and counts mismatches
	sort_perm_monitor u_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.sort_key     (sort_key),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_pixel    (out_pixel),
		.source_index (source_index),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.used_size    (used_size),
		.pending      (pending),
		.fail_count   (fail_count),
		.result_count (result_count)
	);

	// Receiver back-pressure: stall about one cycle in six, except in the quiet stretch
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Watchdog: end the run if no channel moves anything for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Watchdog expired after %0d cycles with no handshake", WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// Hold valid low for a random number of cycles before the next request
	task automatic pause_sender();
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Present one request and hold it until the block takes it
	task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
			input logic [PIX_W-1:0] pix);
		pause_sender();
		in_valid <= 1'b1;
		req_type <= kind;
		sort_key <= key;
		pixel    <= pix;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
	endtask

	// Drop valid and wait until every predicted result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Write used_size only with the block idle; loads leave no result to wait on,
	// so let the chain settle the last one first
	task automatic write_size(input logic [SIZE_W-1:0] size);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		used_size <= size;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		size_writes++;
	endtask

	function automatic logic [KEY_W-1:0] pick_key(input key_mix_e mix,
			input logic [KEY_W-1:0] base);
		case (mix)
			KEYS_TIED: return base + KEY_W'($urandom_range(0, 3));
			KEYS_EDGES: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return '1;
					default: return KEY_W'($urandom);
				endcase
			end
			default: return KEY_W'($urandom);
		endcase
	endfunction

	initial begin
		int               block_items;
		int               n;
		int               partial;
		logic [SIZE_W-1:0] size;
		key_mix_e         mix;
		logic [KEY_W-1:0] base;

		// Drive every input to a known value before reset releases
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		req_type  <= REQ_LOAD;
		sort_key  <= '0;
		pixel     <= '0;
		cfg_valid <= 1'b0;
		used_size <= SIZE_RESET;
		no_gaps   <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// At the reset size: an early fetch gives nothing, a lone load stays partial
		send_request(REQ_FETCH, '1, '1);
		send_request(REQ_LOAD, KEY_W'(12345), 8'h3C);

		// Size zero acts as one; the write also drops the partial block above
		write_size('0);
		send_request(REQ_FETCH, '0, '0);
		send_request(REQ_LOAD, '1, '1);
		send_request(REQ_LOAD, '0, '0);
		send_request(REQ_FETCH, '0, '0);
		send_request(REQ_FETCH, '0, '0);

		// Four entries with a tie and both key extremes; the early fetch carries junk fields
		write_size(SIZE_W'(4));
		send_request(REQ_LOAD, '0, 8'h00);
		send_request(REQ_LOAD, KEY_W'(5), 8'h01);
		send_request(REQ_FETCH, '1, '1);
		send_request(REQ_LOAD, KEY_W'(5), 8'h02);
		send_request(REQ_LOAD, '1, 8'h80);
		repeat (4) send_request(REQ_FETCH, '0, '0);

		// Largest code folds to the full depth; rewriting then empties the partial block
		write_size(SIZE_MAX);
		send_request(REQ_LOAD, KEY_W'(7), 8'h11);
		send_request(REQ_LOAD, KEY_W'(9), 8'h22);
		send_request(REQ_LOAD, KEY_W'(8), 8'h33);
		write_size(SIZE_W'(3));
		send_request(REQ_LOAD, KEY_W'('h2AAAAAAA), 8'h55);
		send_request(REQ_LOAD, KEY_W'('h2AAAAAAA), 8'hAA);
		send_request(REQ_LOAD, KEY_W'('h2AAAAAAA), 8'h0F);
		repeat (3) send_request(REQ_FETCH, '0, '0);

		// Random part: whole blocks (load n, fetch n) with a little noise mixed in
		block_items = 0;
		while (block_items < ITEM_GOAL) begin
			case ($urandom_range(0, 9))
				0: begin
					size = SIZE_W'(1);
					n = 1;
				end
				1: begin
					size = SIZE_W'(BLOCK_DEPTH);
					n = BLOCK_DEPTH;
				end
				2: begin
					size = '0;
					n = 1;
				end
				3: begin
					size = SIZE_W'($urandom_range(BLOCK_DEPTH + 1, int'(SIZE_MAX)));
					n = BLOCK_DEPTH;
				end
				default: begin
					n = $urandom_range(2, 16);
					size = SIZE_W'(n);
				end
			endcase
			write_size(size);

			// Now and then abandon a partly loaded block with a register write
			if (n > 1 && $urandom_range(0, 5) == 0) begin
				partial = $urandom_range(1, n - 1);
				repeat (partial) send_request(REQ_LOAD, KEY_W'($urandom), PIX_W'($urandom));
				block_items += partial;
				write_size(size);
			end

			repeat ($urandom_range(1, 3)) begin
				mix = key_mix_e'($urandom_range(0, 2));
				base = KEY_W'($urandom);
				for (int i = 0; i < n; i++) begin
					// early fetch: ignored by the block
					if ($urandom_range(0, 19) == 0)
						send_request(REQ_FETCH, KEY_W'($urandom), PIX_W'($urandom));
					send_request(REQ_LOAD, pick_key(mix, base), PIX_W'($urandom));
					block_items++;
				end
				// load into a full block: dropped
				if ($urandom_range(0, 7) == 0)
					send_request(REQ_LOAD, KEY_W'($urandom), PIX_W'($urandom));
				for (int i = 0; i < n; i++) begin
					// hold off until the output side has caught up
					if ($urandom_range(0, 49) == 0)
						drain_results();
					send_request(REQ_FETCH, KEY_W'($urandom), PIX_W'($urandom));
					block_items++;
				end
				no_gaps <= (block_items >= QUIET_FROM && block_items < QUIET_TO);
			end
		end

		// Advance until every expectation is met, then let the pipeline settle
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests and checked %0d results over %0d block size writes.",
			requests_sent, result_count, size_writes);
		$display("Blocks used tied, extreme and random keys with early fetches and dropped loads.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
